/* src/virtqueue_indirect_pop_engine_top_assert.svh */
// Assertion macros for the engine; vqip_core is the module that uses them.
// Each expects clk and rst_n to be visible where it is used.
`ifndef VIRTQUEUE_INDIRECT_POP_ENGINE_TOP_ASSERT_SVH
`define VIRTQUEUE_INDIRECT_POP_ENGINE_TOP_ASSERT_SVH

`define VQIP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define VQIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/vqip_pkg.sv */
package vqip_pkg;

  localparam int MAX_QUEUE_DEF = 1024;
  localparam int POS_W         = 10;
  localparam int SETTLE_LEN    = 12;
  localparam int SETTLE_W      = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 44;

  localparam logic [4:0] SIZE_ENTRY = 5'd2;
  localparam logic [4:0] SIZE_WORD  = 5'd4;
  localparam logic [4:0] SIZE_DESC  = 5'd16;

  typedef enum logic [1:0] {
    OP_POP   = 2'd0,
    OP_ENTRY = 2'd1,
    OP_DESC  = 2'd2,
    OP_DONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_SEGMENT = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_HEAD     = 3'd0,
    ERR_NOT_INDIRECT = 3'd1,
    ERR_BAD_TABLE    = 3'd2,
    ERR_CHAIN_LONG   = 3'd3,
    ERR_UNEXPECTED   = 3'd4,
    ERR_NOT_SET_UP   = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ENTRY = 2'd1,
    PH_TOP   = 2'd2,
    PH_WALK  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_PFN  = 2'd0,
    CFG_PAGE_SHIFT = 2'd1,
    CFG_QUEUE_SIZE = 2'd2,
    CFG_RING_ALIGN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] entry_value;
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [15:0] desc_flags;
    logic [15:0] desc_next;
    logic [9:0]  done_id;
    logic [31:0] done_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] mem_address;
    logic [4:0]  access_size;
    logic [31:0] write_value;
    logic [63:0] segment_base;
    logic [31:0] segment_len;
    logic        segment_writable;
    logic [9:0]  request_head;
    logic [31:0] writable_total;
    logic [10:0] segment_count;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             busy;
    logic             setup;
    logic [10:0]      eff_size;
    logic [63:0]      desc_base;
    logic [63:0]      avail_base;
    logic [63:0]      used_base;
    logic             mod_load;
    logic [POS_W-1:0] avail_mod;
    logic [POS_W-1:0] used_mod;
  } geom_t;

  function automatic out_item_t req_item(kind_t kind, logic [63:0] addr,
                                         logic [4:0] size, logic [31:0] val,
                                         logic last);
    out_item_t r;
    r             = '0;
    r.kind        = kind;
    r.mem_address = addr;
    r.access_size = size;
    r.write_value = val;
    r.last        = last;
    return r;
  endfunction

  function automatic out_item_t err_item(err_t code);
    out_item_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

/* src/vqip_geom.sv */
module vqip_geom
  import vqip_pkg::*;
#(
  parameter int MAX_QUEUE = MAX_QUEUE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [POS_W-1:0]      avail_pos,
  input  logic [POS_W-1:0]      used_pos,
  output geom_t                 geom
);

  logic [43:0]         pfn_r, pfn_nxt;
  logic [4:0]          shift_r, shift_nxt;
  logic [10:0]         qsize_r, qsize_nxt;
  logic [16:0]         align_r, align_nxt;
  logic [SETTLE_W-1:0] cnt_r, cnt_nxt;
  logic [10:0]         eff_r;
  logic [17:0]         gap_r;
  logic [63:0]         desc_base_r, avail_base_r, used_pre_r, used_base_r;
  logic                setup_r;
  logic [POS_W-1:0]    arem_r, urem_r, arem_nxt, urem_nxt;
  logic [10:0]         at, ut;
  logic [3:0]          bit_idx;
  logic                cfg_wr, step;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    pfn_nxt   = pfn_r;
    shift_nxt = shift_r;
    qsize_nxt = qsize_r;
    align_nxt = align_r;
    if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QUEUE_PFN:  pfn_nxt   = cfg_data[43:0];
        CFG_PAGE_SHIFT: shift_nxt = cfg_data[4:0];
        CFG_QUEUE_SIZE: qsize_nxt = cfg_data[10:0];
        CFG_RING_ALIGN: align_nxt = cfg_data[16:0];
        default: ;
      endcase
    end
    if (cfg_wr) begin
      cnt_nxt = '0;
    end else if (cnt_r != SETTLE_W'(SETTLE_LEN)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // The ring positions are reduced modulo the queue size one bit per cycle.
  assign step    = (cnt_r >= SETTLE_W'(1)) && (cnt_r <= SETTLE_W'(POS_W));
  assign bit_idx = 4'(POS_W) - 4'(cnt_r);
  assign at      = {arem_r, avail_pos[bit_idx]};
  assign ut      = {urem_r, used_pos[bit_idx]};

  always_comb begin
    arem_nxt = arem_r;
    urem_nxt = urem_r;
    if (cnt_r == '0) begin
      arem_nxt = '0;
      urem_nxt = '0;
    end else if (step) begin
      arem_nxt = (at >= eff_r) ? POS_W'(at - eff_r) : POS_W'(at);
      urem_nxt = (ut >= eff_r) ? POS_W'(ut - eff_r) : POS_W'(ut);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfn_r   <= '0;
      shift_r <= 5'd12;
      qsize_r <= 11'd256;
      align_r <= 17'd4096;
      cnt_r   <= '0;
    end else begin
      pfn_r   <= pfn_nxt;
      shift_r <= shift_nxt;
      qsize_r <= qsize_nxt;
      align_r <= align_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eff_r        <= (32'(qsize_r) > MAX_QUEUE) ? 11'(MAX_QUEUE) : qsize_r;
    desc_base_r  <= 64'(pfn_r) << shift_r;
    gap_r        <= 18'(eff_r) + 18'(eff_r) + 18'd4 + 18'(align_r) - 18'd1;
    avail_base_r <= desc_base_r + {49'b0, eff_r, 4'b0};
    setup_r      <= (desc_base_r != '0) && (eff_r != '0) && (align_r != '0);
    used_pre_r   <= avail_base_r + 64'(gap_r);
    used_base_r  <= used_pre_r & ~(64'(align_r) - 64'd1);
    arem_r       <= arem_nxt;
    urem_r       <= urem_nxt;
  end

  always_comb begin
    geom.busy       = (cnt_r != SETTLE_W'(SETTLE_LEN));
    geom.setup      = setup_r;
    geom.eff_size   = eff_r;
    geom.desc_base  = desc_base_r;
    geom.avail_base = avail_base_r;
    geom.used_base  = used_base_r;
    geom.mod_load   = (cnt_r == SETTLE_W'(SETTLE_LEN - 1));
    geom.avail_mod  = arem_r;
    geom.used_mod   = urem_r;
  end

endmodule

/* src/vqip_core.sv */
`include "virtqueue_indirect_pop_engine_top_assert.svh"

module vqip_core
  import vqip_pkg::*;
#(
  parameter int MAX_QUEUE = MAX_QUEUE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  geom_t            geom,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  output logic [POS_W-1:0] avail_pos,
  output logic [POS_W-1:0] used_pos
);

  localparam int SEEN_W = $clog2(MAX_QUEUE + 1);

  in_item_t         in_r, in_nxt;
  logic             in_vld_r, in_vld_nxt;
  out_item_t        res_a_r, res_a_nxt, res_b_r, res_b_nxt, r0, r1;
  logic [1:0]       res_cnt_r, res_cnt_nxt;
  logic             two;
  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] apos_r, apos_nxt, upos_r, upos_nxt;
  logic [POS_W-1:0] amod_r, amod_nxt, umod_r, umod_nxt;
  logic [9:0]       head_r, head_nxt;
  logic [63:0]      tbase_r, tbase_nxt;
  logic [31:0]      wsum_r, wsum_nxt, wsum_inc;
  logic [SEEN_W-1:0] seen_r, seen_nxt, seen_inc;
  logic [63:0]      used_pa;
  logic             out_take, in_take, load, wr, more;

  assign out_take = out_valid && !out_stall;
  assign load     = in_vld_r && !geom.busy &&
                    ((res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && out_take));
  assign in_stall = geom.busy || (in_vld_r && !load);
  assign in_take  = in_valid && !in_stall;

  assign wr       = in_r.desc_flags[1];
  assign more     = in_r.desc_flags[0];
  assign wsum_inc = wsum_r + (wr ? in_r.desc_len : 32'd0);
  assign seen_inc = seen_r + 1'b1;
  assign used_pa  = geom.used_base + {51'b0, umod_r, 3'b100};

  always_comb begin
    r0        = '0;
    r1        = '0;
    two       = 1'b0;
    phase_nxt = phase_r;
    apos_nxt  = apos_r;
    amod_nxt  = amod_r;
    upos_nxt  = upos_r;
    umod_nxt  = umod_r;
    head_nxt  = head_r;
    tbase_nxt = tbase_r;
    wsum_nxt  = wsum_r;
    seen_nxt  = seen_r;
    case (op_t'(in_r.opcode))
      OP_DONE: begin
        if (!geom.setup) begin
          r0 = err_item(ERR_NOT_SET_UP);
        end else begin
          r0       = req_item(KIND_WRITE, used_pa, SIZE_WORD, 32'(in_r.done_id), 1'b0);
          r1       = req_item(KIND_WRITE, geom.used_base + {50'b0, 11'(umod_r) + 11'd1,
                              3'b000}, SIZE_WORD, in_r.done_len, 1'b1);
          two      = 1'b1;
          upos_nxt = upos_r + 1'b1;
          umod_nxt = ((upos_r == '1) || (11'(umod_r) + 11'd1 == geom.eff_size)) ?
                     '0 : umod_r + 1'b1;
        end
      end
      OP_POP: begin
        if (phase_r != PH_IDLE) begin
          r0 = err_item(ERR_UNEXPECTED);
        end else if (!geom.setup) begin
          r0 = err_item(ERR_NOT_SET_UP);
        end else begin
          r0        = req_item(KIND_READ, geom.avail_base + {53'b0, amod_r, 1'b0} + 64'd4,
                               SIZE_ENTRY, 32'd0, 1'b1);
          apos_nxt  = apos_r + 1'b1;
          amod_nxt  = ((apos_r == '1) || (11'(amod_r) + 11'd1 == geom.eff_size)) ?
                      '0 : amod_r + 1'b1;
          phase_nxt = PH_ENTRY;
        end
      end
      OP_ENTRY: begin
        if (phase_r != PH_ENTRY) begin
          r0 = err_item(ERR_UNEXPECTED);
        end else if (in_r.entry_value >= {5'b0, geom.eff_size}) begin
          r0        = err_item(ERR_BAD_HEAD);
          phase_nxt = PH_IDLE;
        end else begin
          r0        = req_item(KIND_READ, geom.desc_base + {44'b0, in_r.entry_value, 4'b0},
                               SIZE_DESC, 32'd0, 1'b1);
          head_nxt  = in_r.entry_value[9:0];
          phase_nxt = PH_TOP;
        end
      end
      default: begin
        if (phase_r == PH_TOP) begin
          if (!in_r.desc_flags[2]) begin
            r0        = err_item(ERR_NOT_INDIRECT);
            phase_nxt = PH_IDLE;
          end else if ((in_r.desc_len == '0) || (in_r.desc_len[3:0] != 4'd0)) begin
            r0        = err_item(ERR_BAD_TABLE);
            phase_nxt = PH_IDLE;
          end else begin
            r0        = req_item(KIND_READ, in_r.desc_addr, SIZE_DESC, 32'd0, 1'b1);
            tbase_nxt = in_r.desc_addr;
            wsum_nxt  = '0;
            seen_nxt  = '0;
            phase_nxt = PH_WALK;
          end
        end else if (phase_r == PH_WALK) begin
          if (32'(seen_r) >= MAX_QUEUE) begin
            r0        = err_item(ERR_CHAIN_LONG);
            phase_nxt = PH_IDLE;
          end else begin
            r0.kind             = KIND_SEGMENT;
            r0.segment_base     = in_r.desc_addr;
            r0.segment_len      = in_r.desc_len;
            r0.segment_writable = wr;
            two                 = 1'b1;
            wsum_nxt            = wsum_inc;
            seen_nxt            = seen_inc;
            if (more) begin
              r1 = req_item(KIND_READ, tbase_r + {44'b0, in_r.desc_next, 4'b0},
                            SIZE_DESC, 32'd0, 1'b1);
            end else begin
              r1.kind           = KIND_DONE;
              r1.request_head   = head_r;
              r1.writable_total = wsum_inc;
              r1.segment_count  = 11'(32'(seen_inc));
              r1.last           = 1'b1;
              phase_nxt         = PH_IDLE;
            end
          end
        end else begin
          r0 = err_item(ERR_UNEXPECTED);
        end
      end
    endcase
  end

  always_comb begin
    in_nxt      = in_take ? in_data : in_r;
    in_vld_nxt  = in_take || (in_vld_r && !load);
    res_a_nxt   = res_a_r;
    res_b_nxt   = res_b_r;
    res_cnt_nxt = res_cnt_r;
    if (load) begin
      res_a_nxt   = r0;
      res_b_nxt   = r1;
      res_cnt_nxt = two ? 2'd2 : 2'd1;
    end else if (out_take) begin
      res_a_nxt   = res_b_r;
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_cnt_r <= '0;
      phase_r   <= PH_IDLE;
      apos_r    <= '0;
      upos_r    <= '0;
      amod_r    <= '0;
      umod_r    <= '0;
      head_r    <= '0;
      tbase_r   <= '0;
      wsum_r    <= '0;
      seen_r    <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      res_cnt_r <= res_cnt_nxt;
      if (load) begin
        phase_r <= phase_nxt;
        apos_r  <= apos_nxt;
        upos_r  <= upos_nxt;
        amod_r  <= amod_nxt;
        umod_r  <= umod_nxt;
        head_r  <= head_nxt;
        tbase_r <= tbase_nxt;
        wsum_r  <= wsum_nxt;
        seen_r  <= seen_nxt;
      end else if (geom.mod_load) begin
        amod_r <= geom.avail_mod;
        umod_r <= geom.used_mod;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
  end

  assign out_valid = (res_cnt_r != 2'd0);
  assign out_data  = res_a_r;
  assign avail_pos = apos_r;
  assign used_pos  = upos_r;

  `VQIP_ASSERT_ALWAYS(a_pair_first_not_last, (res_cnt_r != 2'd2) || !res_a_r.last, "first of a result pair is marked last")
  `VQIP_ASSERT_ALWAYS(a_seen_bound, 32'(seen_r) <= MAX_QUEUE, "segment count beyond the chain limit")
  `VQIP_ASSERT_ALWAYS(a_mod_range, geom.busy || !geom.setup || ((11'(amod_r) < geom.eff_size) && (11'(umod_r) < geom.eff_size)), "ring offset not below the queue size")
  `VQIP_ASSERT_NEXT(a_input_held, in_vld_r && !load, in_vld_r && $stable(in_r), "held item lost from the input register")

endmodule

/* src/virtqueue_indirect_pop_engine_top.sv */
// An accepted item waits in the input register and moves into the result register once
// that is free and no settling pass runs. One item per cycle is taken while the result
// side does not stall; an item with two results holds the next item back while the pair
// drains through the single result port. Reset and every configuration write start a
// settling pass that recomputes ring bases and ring offsets; no item is accepted during it.
module virtqueue_indirect_pop_engine_top
  import vqip_pkg::*;
#(
  parameter int MAX_QUEUE = MAX_QUEUE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  geom_t            geom;
  logic [POS_W-1:0] avail_pos, used_pos;

  vqip_geom #(
    .MAX_QUEUE(MAX_QUEUE)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .avail_pos (avail_pos),
    .used_pos  (used_pos),
    .geom      (geom)
  );

  vqip_core #(
    .MAX_QUEUE(MAX_QUEUE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .avail_pos (avail_pos),
    .used_pos  (used_pos)
  );

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vqip_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #5 clk = ~clk;

  virtqueue_indirect_pop_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  in_item_t  items_to_send[$];
  out_item_t results_due[$];
  int        items_queued = 0;
  int        items_in     = 0;
  int        fails        = 0;
  int        quiet        = 0;
  bit        in_taken     = 1'b0;
  bit        cfg_taken    = 1'b0;
  int        gen_len      = 256;

  int burst_left = 8;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  int hold_left  = 0;
  int next_hold  = 400;

  logic [43:0] q_pfn;
  logic [4:0]  q_shift;
  logic [10:0] q_size;
  logic [16:0] q_align;
  phase_t      ring_phase;
  logic [9:0]  avail_pos;
  logic [9:0]  used_pos;
  logic [9:0]  head_idx;
  logic [63:0] tbl_base;
  logic [31:0] wr_sum;
  logic [10:0] seg_cnt;

  function automatic logic [10:0] ring_len();
    return (q_size > 11'(MAX_QUEUE_DEF)) ? 11'(MAX_QUEUE_DEF) : q_size;
  endfunction

  function automatic logic [63:0] table_addr();
    return 64'(q_pfn) << q_shift;
  endfunction

  function automatic logic [63:0] avail_addr();
    return table_addr() + 64'(ring_len()) * 64'd16;
  endfunction

  function automatic logic [63:0] used_addr();
    logic [63:0] x;
    logic [63:0] a;
    x = avail_addr() + 64'd4 + 64'(ring_len()) * 64'd2;
    a = 64'(q_align);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic bit ring_ready();
    return table_addr() != 64'd0 && ring_len() != 11'd0 && q_align != 17'd0;
  endfunction

  function automatic out_item_t mem_access(kind_t k, logic [63:0] addr, logic [4:0] size,
                                           logic [31:0] val, logic last);
    out_item_t r;
    r             = '0;
    r.kind        = k;
    r.mem_address = addr;
    r.access_size = size;
    r.write_value = val;
    r.last        = last;
    return r;
  endfunction

  function automatic out_item_t fault(err_t code);
    out_item_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  task automatic virtq_step(in_item_t it);
    out_item_t   r;
    logic [63:0] pa;
    r = '0;
    case (op_t'(it.opcode))
      OP_DONE: begin
        if (!ring_ready()) begin
          results_due.push_back(fault(ERR_NOT_SET_UP));
        end else begin
          pa = used_addr() + 64'd4 + 64'd8 * (64'(used_pos) % 64'(ring_len()));
          results_due.push_back(mem_access(KIND_WRITE, pa, SIZE_WORD, 32'(it.done_id), 1'b0));
          results_due.push_back(mem_access(KIND_WRITE, pa + 64'd4, SIZE_WORD, it.done_len,
                                           1'b1));
          used_pos = used_pos + 10'd1;
        end
      end
      OP_POP: begin
        if (ring_phase != PH_IDLE) begin
          results_due.push_back(fault(ERR_UNEXPECTED));
        end else if (!ring_ready()) begin
          results_due.push_back(fault(ERR_NOT_SET_UP));
        end else begin
          pa = avail_addr() + 64'd4 + 64'd2 * (64'(avail_pos) % 64'(ring_len()));
          avail_pos  = avail_pos + 10'd1;
          ring_phase = PH_ENTRY;
          results_due.push_back(mem_access(KIND_READ, pa, SIZE_ENTRY, 32'd0, 1'b1));
        end
      end
      OP_ENTRY: begin
        if (ring_phase != PH_ENTRY) begin
          results_due.push_back(fault(ERR_UNEXPECTED));
        end else if (64'(it.entry_value) >= 64'(ring_len())) begin
          ring_phase = PH_IDLE;
          results_due.push_back(fault(ERR_BAD_HEAD));
        end else begin
          head_idx   = it.entry_value[9:0];
          ring_phase = PH_TOP;
          results_due.push_back(mem_access(KIND_READ,
                                           table_addr() + 64'(it.entry_value) * 64'd16,
                                           SIZE_DESC, 32'd0, 1'b1));
        end
      end
      default: begin
        case (ring_phase)
          PH_TOP: begin
            if (!it.desc_flags[2]) begin
              ring_phase = PH_IDLE;
              results_due.push_back(fault(ERR_NOT_INDIRECT));
            end else if (it.desc_len == 32'd0 || it.desc_len[3:0] != 4'd0) begin
              ring_phase = PH_IDLE;
              results_due.push_back(fault(ERR_BAD_TABLE));
            end else begin
              tbl_base   = it.desc_addr;
              wr_sum     = 32'd0;
              seg_cnt    = 11'd0;
              ring_phase = PH_WALK;
              results_due.push_back(mem_access(KIND_READ, tbl_base, SIZE_DESC, 32'd0, 1'b1));
            end
          end
          PH_WALK: begin
            if (seg_cnt >= 11'(MAX_QUEUE_DEF)) begin
              ring_phase = PH_IDLE;
              results_due.push_back(fault(ERR_CHAIN_LONG));
            end else begin
              r.kind             = KIND_SEGMENT;
              r.segment_base     = it.desc_addr;
              r.segment_len      = it.desc_len;
              r.segment_writable = it.desc_flags[1];
              if (it.desc_flags[1]) wr_sum = wr_sum + it.desc_len;
              seg_cnt = seg_cnt + 11'd1;
              results_due.push_back(r);
              if (it.desc_flags[0]) begin
                results_due.push_back(mem_access(KIND_READ,
                                                 tbl_base + 64'(it.desc_next) * 64'd16,
                                                 SIZE_DESC, 32'd0, 1'b1));
              end else begin
                r                = '0;
                r.kind           = KIND_DONE;
                r.request_head   = head_idx;
                r.writable_total = wr_sum;
                r.segment_count  = seg_cnt;
                r.last           = 1'b1;
                results_due.push_back(r);
                ring_phase = PH_IDLE;
              end
            end
          end
          default: results_due.push_back(fault(ERR_UNEXPECTED));
        endcase
      end
    endcase
  endtask

  function automatic bit same(string nm, logic [63:0] want, logic [63:0] got);
    if (want === got) return 1'b1;
    $display("%0t ns: %s expected %0h got %0h", $time, nm, want, got);
    return 1'b0;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    bit        ok;
    if (results_due.size() == 0) begin
      $display("%0t ns: result expected none got %h", $time, got);
      fails++;
    end else begin
      want = results_due.pop_front();
      ok = same("kind", want.kind, got.kind)
         & same("mem_address", want.mem_address, got.mem_address)
         & same("access_size", want.access_size, got.access_size)
         & same("write_value", want.write_value, got.write_value)
         & same("segment_base", want.segment_base, got.segment_base)
         & same("segment_len", want.segment_len, got.segment_len)
         & same("segment_writable", want.segment_writable, got.segment_writable)
         & same("request_head", want.request_head, got.request_head)
         & same("writable_total", want.writable_total, got.writable_total)
         & same("segment_count", want.segment_count, got.segment_count)
         & same("error_code", want.error_code, got.error_code)
         & same("last", want.last, got.last);
      if (!ok) fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      q_pfn      = '0;
      q_shift    = 5'd12;
      q_size     = 11'd256;
      q_align    = 17'd4096;
      ring_phase = PH_IDLE;
      avail_pos  = '0;
      used_pos   = '0;
      head_idx   = '0;
      tbl_base   = '0;
      wr_sum     = '0;
      seg_cnt    = '0;
      quiet      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        virtq_step(in_data);
        items_in++;
        in_taken = 1'b1;
        moved    = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_QUEUE_PFN:  q_pfn   = cfg_data;
          CFG_PAGE_SHIFT: q_shift = cfg_data[4:0];
          CFG_QUEUE_SIZE: q_size  = cfg_data[10:0];
          default:        q_align = cfg_data[16:0];
        endcase
        cfg_taken = 1'b1;
        moved     = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin : drive
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= items_to_send.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(5) == 0) ? 100 : $urandom_range(40, 1);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // A long hold-off on the result side lets the engine fill up and push back.
  always @(negedge clk) begin : receive
    stall_tick++;
    if (stall_tick == 64) begin
      stall_tick = 0;
      stall_mode = $urandom_range(3);
    end
    if (hold_left == 0 && items_in >= next_hold && items_to_send.size() > 20) begin
      hold_left = HOLD_CYCLES;
      next_hold = next_hold + 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(1));
        2:       out_stall <= (stall_tick % 4) != 0;
        default: out_stall <= ($urandom_range(9) == 0);
      endcase
    end
  end

  function automatic in_item_t fresh(op_t op);
    in_item_t it;
    it.opcode      = op;
    it.entry_value = 16'($urandom);
    it.desc_addr   = {$urandom, $urandom};
    it.desc_len    = $urandom;
    it.desc_flags  = 16'($urandom);
    it.desc_next   = 16'($urandom);
    it.done_id     = 10'($urandom);
    it.done_len    = $urandom;
    return it;
  endfunction

  function automatic in_item_t entry_of(logic [15:0] v);
    in_item_t it;
    it             = fresh(OP_ENTRY);
    it.entry_value = v;
    return it;
  endfunction

  function automatic in_item_t desc_of(logic [63:0] addr, logic [31:0] len,
                                       logic [15:0] flags, logic [15:0] nxt);
    in_item_t it;
    it            = fresh(OP_DESC);
    it.desc_addr  = addr;
    it.desc_len   = len;
    it.desc_flags = flags;
    it.desc_next  = nxt;
    return it;
  endfunction

  function automatic in_item_t done_of(logic [9:0] id, logic [31:0] len);
    in_item_t it;
    it          = fresh(OP_DONE);
    it.done_id  = id;
    it.done_len = len;
    return it;
  endfunction

  function automatic in_item_t good_entry();
    return entry_of(gen_len > 0 ? 16'($urandom_range(gen_len - 1, 0)) : 16'($urandom));
  endfunction

  function automatic in_item_t bad_entry();
    return entry_of(16'($urandom_range(65535, gen_len)));
  endfunction

  function automatic in_item_t top_desc();
    logic [15:0] fl;
    logic [31:0] ln;
    fl    = 16'($urandom);
    fl[2] = 1'b1;
    ln    = $urandom;
    ln[3:0] = 4'd0;
    if ($urandom_range(3) == 0) ln = 32'(16 * $urandom_range(8, 1));
    if (ln == 32'd0) ln = 32'd16;
    return desc_of({$urandom, $urandom}, ln, fl, 16'($urandom));
  endfunction

  function automatic in_item_t walk_desc(bit more);
    logic [15:0] fl;
    logic [31:0] ln;
    fl    = 16'($urandom);
    fl[0] = more;
    ln    = ($urandom_range(1) == 0) ? 32'($urandom_range(4096)) : $urandom;
    return desc_of({$urandom, $urandom}, ln, fl, 16'($urandom));
  endfunction

  task automatic send(in_item_t it);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic seq_request(int nseg);
    int k;
    send(fresh(OP_POP));
    send(good_entry());
    send(top_desc());
    for (k = 0; k < nseg; k++) begin
      if ($urandom_range(9) == 0) send(fresh(OP_DONE));
      send(walk_desc(k < nseg - 1));
    end
  endtask

  // Brings the engine back to idle from any phase.
  task automatic seq_flush();
    logic [15:0] fl;
    fl    = 16'($urandom);
    fl[0] = 1'b0;
    fl[2] = 1'b0;
    send(bad_entry());
    send(desc_of({$urandom, $urandom}, $urandom, fl, 16'($urandom)));
  endtask

  task automatic seq_broken();
    logic [15:0] fl;
    logic [31:0] ln;
    fl = 16'($urandom);
    ln = $urandom;
    case ($urandom_range(6))
      0: begin
        send(fresh(OP_POP));
        send(bad_entry());
      end
      1: begin
        fl[2] = 1'b0;
        send(fresh(OP_POP));
        send(good_entry());
        send(desc_of({$urandom, $urandom}, ln, fl, 16'($urandom)));
      end
      2: begin
        fl[2] = 1'b1;
        if (ln[3:0] == 4'd0) ln[3:0] = 4'(1 << $urandom_range(3));
        if ($urandom_range(2) == 0) ln = 32'd0;
        send(fresh(OP_POP));
        send(good_entry());
        send(desc_of({$urandom, $urandom}, ln, fl, 16'($urandom)));
      end
      3: begin
        send(fresh(OP_POP));
        send(fresh(OP_POP));
        send(bad_entry());
      end
      4: begin
        send(fresh(OP_POP));
        send(fresh(OP_DESC));
        send(bad_entry());
      end
      5: begin
        fl[2] = 1'b0;
        send(fresh(OP_POP));
        send(good_entry());
        send(fresh(OP_ENTRY));
        send(fresh(OP_POP));
        send(desc_of({$urandom, $urandom}, ln, fl, 16'($urandom)));
      end
      default: begin
        send(fresh(OP_ENTRY));
        send(fresh(OP_DESC));
        send(fresh(OP_POP));
        send(good_entry());
        send(top_desc());
        send(fresh(OP_POP));
        send(fresh(OP_ENTRY));
        send(walk_desc(1'b0));
      end
    endcase
  endtask

  task automatic fill_random(int n);
    int start;
    int r;
    start = items_queued;
    while (items_queued - start < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        seq_request(($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1));
      end else if (r < 75) begin
        repeat ($urandom_range(3, 1)) send(fresh(OP_DONE));
      end else if (r < 90) begin
        seq_broken();
      end else begin
        repeat ($urandom_range(6, 1)) send(fresh(op_t'($urandom_range(3))));
        seq_flush();
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (items_in != items_queued || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [43:0] pfn, logic [4:0] sh, logic [10:0] qs,
                           logic [16:0] al);
    write_reg(CFG_QUEUE_PFN, pfn);
    write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(sh));
    write_reg(CFG_QUEUE_SIZE, CFG_DATA_W'(qs));
    write_reg(CFG_RING_ALIGN, CFG_DATA_W'(al));
    gen_len = (qs > 11'(MAX_QUEUE_DEF)) ? MAX_QUEUE_DEF : int'(qs);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(fresh(OP_POP));
    send(fresh(OP_DONE));
    send(fresh(OP_ENTRY));
    send(fresh(OP_DESC));
    drain();

    configure(44'd1, 5'd12, 11'd4, 17'd4);
    send(fresh(OP_POP));
    send(entry_of(16'd3));
    send(desc_of(64'd0, 32'd16, 16'h0004, 16'h0000));
    send(desc_of('1, '1, 16'h0003, 16'hFFFF));
    send(desc_of(64'd0, 32'hFFFF_FFFF, 16'hFFFA, 16'h0000));
    send(fresh(OP_POP));
    send(entry_of(16'd4));
    send(fresh(OP_POP));
    send(entry_of(16'hFFFF));
    send(fresh(OP_POP));
    send(entry_of(16'd0));
    send(desc_of('1, '1, 16'hFFFB, 16'hFFFF));
    send(fresh(OP_POP));
    send(entry_of(16'd1));
    send(desc_of(64'd0, 32'd0, 16'h0004, 16'h0000));
    send(fresh(OP_POP));
    send(entry_of(16'd2));
    send(desc_of(64'd0, 32'd24, 16'h0004, 16'h0000));
    send(fresh(OP_POP));
    send(fresh(OP_POP));
    send(entry_of(16'd2));
    send(entry_of(16'd0));
    send(desc_of('1, 32'hFFFF_FFF0, 16'hFFFF, 16'h0000));
    send(desc_of(64'd0, 32'd0, 16'h0000, 16'h0000));
    send(done_of(10'h3FF, 32'hFFFF_FFFF));
    send(done_of(10'h000, 32'h0000_0000));
    drain();

    configure(44'({$urandom, $urandom}), 5'd12, 11'd256, 17'd4096);
    fill_random(20);
    drain();
    configure('1, 5'd20, 11'd1024, 17'd65536);
    fill_random(20);
    drain();
    configure(44'd1, 5'd0, 11'd1, 17'd1);
    fill_random(12);
    drain();
    configure(44'({$urandom, $urandom}), 5'd31, 11'd2047, 17'd2);
    fill_random(12);
    drain();
    configure(44'({$urandom, $urandom}), 5'd12, 11'd0, 17'd4096);
    fill_random(6);
    drain();
    configure(44'({$urandom, $urandom}), 5'd12, 11'd64, 17'd0);
    fill_random(6);
    drain();
    configure(44'd0, 5'd12, 11'd64, 17'd4096);
    fill_random(6);
    drain();
    repeat (3) begin
      configure(44'({$urandom, $urandom}), 5'($urandom_range(20)),
                ($urandom_range(2) == 0) ? 11'($urandom_range(2047, 1))
                                         : 11'($urandom_range(64, 1)),
                17'(1 << $urandom_range(16)));
      fill_random(8);
      drain();
    end

    // A chain one descriptor longer than the limit ends in an error.
    configure(44'({$urandom, $urandom}), 5'd12, 11'd1024, 17'd4096);
    send(fresh(OP_POP));
    send(good_entry());
    send(top_desc());
    for (k = 0; k <= MAX_QUEUE_DEF; k++) begin
      if (k % 64 == 0) send(fresh(OP_DONE));
      send(walk_desc(k < MAX_QUEUE_DEF));
    end
    drain();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/vqip_pkg.sv
src/vqip_geom.sv
src/vqip_core.sv
src/virtqueue_indirect_pop_engine_top.sv
test/tb.sv
